>>> src/arpc_pkg.sv
// Package for the ARP cache table: item structs, opcodes, FSM states and defaults.
// Used by arp_cache_table and the testbench; depends on nothing else.
`default_nettype none

package arpc_pkg;

  // Default table size and reset value of the timeout register.
  localparam int unsigned TABLE_ENTRIES_DEF = 16;
  localparam logic [15:0] TIMEOUT_RESET     = 16'd15;

  // Width of the reported slot number.
  localparam int unsigned SLOT_W = 4;

  // Operation codes carried in the opcode field of an input item.
  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_TICK   = 2'd2
  } op_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_INSERT,
    ST_TICK,
    ST_RESP
  } state_t;

  // One input item.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] ip_address;
    logic [47:0] mac_address;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic              found;
    logic [47:0]       found_mac;
    logic              stored;
    logic [SLOT_W-1:0] slot_index;
  } out_item_t;

  // One table entry as kept in the entry memory.
  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] added_time;
  } entry_t;

endpackage

`default_nettype wire

>>> src/arpc_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stands alone; no package needed.
`default_nettype none

module arpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/arp_cache_table.sv
// Top level of the ARP cache table: controller, valid bits, clock and timeout registers.
// Depends on arpc_pkg and arpc_ram.
`default_nettype none

// The table keeps TABLE_ENTRIES entries of IP, MAC and insertion time in one
// synchronous memory; valid bits live in flip-flops and are cleared at reset.
// An item is taken when start is high and busy is low, and one result item is
// shown on out_item for exactly one cycle with out_valid high; the receiver
// cannot stall it, so it must take every result. A lookup or a tick reads
// every entry through the single memory read port, one entry per cycle,
// before its result is shown. An insert walks the valid bits up to the first
// free slot and stores there, or stops at the last slot when the table is
// full. An unused opcode goes straight to the result. After each result the
// block returns to idle, where it can take the next item. The timeout
// register may be written only while busy is low.
module arp_cache_table
  import arpc_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  output out_item_t        out_item,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned ENT_W = $bits(entry_t);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     pend_r, pend_nxt;
  logic [IDX_W-1:0]         pend_idx_r, pend_idx_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [31:0]              now_r;
  logic [15:0]              timeout_r;
  logic [31:0]              ip_r;
  logic [47:0]              mac_r;
  logic                     found_r, found_nxt;
  logic [47:0]              fmac_r, fmac_nxt;
  logic                     stored_r, stored_nxt;
  logic [SLOT_W-1:0]        slot_r, slot_nxt;

  logic                     accept;
  logic [IDX_W-1:0]         cnt_idx;
  logic                     set_en, clr_en;
  logic [IDX_W-1:0]         clr_idx;
  logic [ENT_W-1:0]         rd_raw;
  entry_t                   rd_entry;
  entry_t                   wr_entry;
  logic [31:0]              age;

  assign accept   = start && !busy;
  assign cnt_idx  = cnt_r[IDX_W-1:0];
  assign rd_entry = entry_t'(rd_raw);
  assign age      = now_r - rd_entry.added_time;

  assign wr_entry.ip         = ip_r;
  assign wr_entry.mac        = mac_r;
  assign wr_entry.added_time = now_r;

  // Entry memory: written on insert, read one entry per cycle during a scan.
  arpc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (set_en),
    .waddr (cnt_idx),
    .wdata (wr_entry),
    .raddr (cnt_idx),
    .rdata (rd_raw)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_item.opcode)
            OP_LOOKUP: state_nxt = ST_LOOKUP;
            OP_INSERT: state_nxt = ST_INSERT;
            OP_TICK:   state_nxt = ST_TICK;
            default:   state_nxt = ST_RESP;
          endcase
        end
      end
      ST_LOOKUP, ST_TICK: begin
        if (cnt_r == CNT_END && pend_r) begin
          state_nxt = ST_RESP;
        end
      end
      ST_INSERT: begin
        if (!valid_r[cnt_idx] || cnt_r == CNT_LAST) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Scan counter, read pipeline, valid bit updates and result fields.
  always_comb begin
    cnt_nxt      = cnt_r;
    pend_nxt     = 1'b0;
    pend_idx_nxt = cnt_idx;
    found_nxt    = found_r;
    fmac_nxt     = fmac_r;
    stored_nxt   = stored_r;
    slot_nxt     = slot_r;
    set_en       = 1'b0;
    clr_en       = 1'b0;
    clr_idx      = pend_idx_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt    = '0;
        found_nxt  = 1'b0;
        fmac_nxt   = '0;
        stored_nxt = 1'b0;
        slot_nxt   = '0;
      end
      ST_LOOKUP, ST_TICK: begin
        // Issue one read per cycle; the entry comes back in the next cycle.
        if (cnt_r != CNT_END) begin
          cnt_nxt  = cnt_r + 1'b1;
          pend_nxt = 1'b1;
        end
        if (pend_r && valid_r[pend_idx_r]) begin
          if (state_r == ST_LOOKUP) begin
            // Ascending scan: the last match seen is the highest slot.
            if (rd_entry.ip == ip_r) begin
              found_nxt = 1'b1;
              fmac_nxt  = rd_entry.mac;
              slot_nxt  = SLOT_W'(pend_idx_r);
            end
          end else if (age > {16'd0, timeout_r}) begin
            clr_en = 1'b1;
          end
        end
      end
      ST_INSERT: begin
        // Take the first free slot, else move on to the next one.
        if (!valid_r[cnt_idx]) begin
          set_en     = 1'b1;
          stored_nxt = 1'b1;
          slot_nxt   = SLOT_W'(cnt_idx);
        end else if (cnt_r != CNT_LAST) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // Handshake outputs.
  always_comb begin
    busy                = (state_r != ST_IDLE);
    out_valid           = (state_r == ST_RESP);
    out_item.found      = found_r;
    out_item.found_mac  = fmac_r;
    out_item.stored     = stored_r;
    out_item.slot_index = slot_r;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      pend_r    <= 1'b0;
      valid_r   <= '0;
      now_r     <= '0;
      timeout_r <= TIMEOUT_RESET;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      if (set_en) begin
        valid_r[cnt_idx] <= 1'b1;
      end
      if (clr_en) begin
        valid_r[clr_idx] <= 1'b0;
      end
      // The clock advances when a tick item is taken, before its scan.
      if (accept && in_item.opcode == OP_TICK) begin
        now_r <= now_r + 32'd1;
      end
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    found_r    <= found_nxt;
    fmac_r     <= fmac_nxt;
    stored_r   <= stored_nxt;
    slot_r     <= slot_nxt;
    if (accept) begin
      ip_r  <= in_item.ip_address;
      mac_r <= in_item.mac_address;
    end
  end

  // A result is shown for one cycle only.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // An accepted item keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("block not busy after taking an item");

  // The block goes idle only right after showing a result.
  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> $past(out_valid))
    else $error("block went idle without a result");

  // A result never reports both a lookup hit and an insert.
  a_hit_or_store: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.found && out_item.stored))
    else $error("result marks both found and stored");

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for arp_cache_table: a short directed table followed by random
// traffic in phases with different timeouts, checked against a behavioral cache model or hand-written replies.
// Depends on arpc_pkg and the arp_cache_table RTL.
module tb_top;
  import arpc_pkg::*;

  localparam int unsigned ENTRIES      = TABLE_ENTRIES_DEF;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned POOL_DEPTH   = 24;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  // One row of the directed table; typed rows carry a hand-written reply.
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } step_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  // Model of the cache contents, second counter and timeout register.
  bit          cache_valid [ENTRIES];
  logic [31:0] cache_ip    [ENTRIES];
  logic [47:0] cache_mac   [ENTRIES];
  logic [31:0] cache_stamp [ENTRIES];
  logic [31:0] clock_secs;
  logic [15:0] timeout_secs;

  out_item_t   pending_replies [$];
  logic [31:0] ip_pool [$];
  step_row_t   directed_rows [$];
  int unsigned fail_count;
  int unsigned cycle_count;

  arp_cache_table u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Applies one operation to the cache model and returns the reply it produces.
  function automatic out_item_t cache_apply_op(in_item_t it);
    out_item_t   r;
    logic [31:0] age;
    r = '0;
    case (it.opcode)
      OP_LOOKUP: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (cache_valid[i] && cache_ip[i] == it.ip_address) begin
            r.found      = 1'b1;
            r.found_mac  = cache_mac[i];
            r.slot_index = SLOT_W'(i);
          end
        end
      end
      OP_INSERT: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (!cache_valid[i]) begin
            cache_valid[i] = 1'b1;
            cache_ip[i]    = it.ip_address;
            cache_mac[i]   = it.mac_address;
            cache_stamp[i] = clock_secs;
            r.stored       = 1'b1;
            r.slot_index   = SLOT_W'(i);
            break;
          end
        end
      end
      OP_TICK: begin
        clock_secs = clock_secs + 32'd1;
        for (int i = 0; i < ENTRIES; i++) begin
          age = clock_secs - cache_stamp[i];
          if (cache_valid[i] && age > {16'd0, timeout_secs}) cache_valid[i] = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic out_item_t reply(logic f, logic [47:0] m, logic s, logic [SLOT_W-1:0] k);
    out_item_t r;
    r.found      = f;
    r.found_mac  = m;
    r.stored     = s;
    r.slot_index = k;
    return r;
  endfunction

  function automatic logic [47:0] rand_mac();
    return {16'($urandom), $urandom};
  endfunction

  function automatic in_item_t make_item(logic [1:0] op, logic [31:0] ip, logic [47:0] mac);
    in_item_t it;
    it.opcode      = op;
    it.ip_address  = ip;
    it.mac_address = mac;
    return it;
  endfunction

  task automatic add_row(in_item_t it, bit typed, out_item_t want);
    step_row_t row;
    row.item  = it;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // Presents one item and holds it until the block takes it, then records the reply.
  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    out_item_t predicted;
    @(negedge clk);
    start   <= 1'b1;
    in_item <= it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    predicted = cache_apply_op(it);
    pending_replies.push_back(typed ? want : predicted);
  endtask

  // Keeps start low for a number of cycles, with junk on the item bus.
  task automatic hold_off(int unsigned cycles);
    for (int n = 0; n < cycles; n++) begin
      @(negedge clk);
      start   <= 1'b0;
      in_item <= make_item(2'($urandom), $urandom, rand_mac());
    end
  endtask

  task automatic wait_drained();
    forever begin
      @(posedge clk);
      if (pending_replies.size() == 0 && !busy) break;
    end
  endtask

  // Timeout writes happen only with the block idle and nothing outstanding.
  task automatic set_timeout(logic [15:0] value);
    hold_off(1);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    timeout_secs = value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Every reply strobe is compared with the oldest outstanding expectation.
  always @(posedge clk) begin : reply_check
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        $error("reply with no item outstanding");
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        if (out_item.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_item.found);
          fail_count++;
        end
        if (out_item.found_mac !== want.found_mac) begin
          $error("found_mac: expected %h, got %h", want.found_mac, out_item.found_mac);
          fail_count++;
        end
        if (out_item.stored !== want.stored) begin
          $error("stored: expected %0d, got %0d", want.stored, out_item.stored);
          fail_count++;
        end
        if (out_item.slot_index !== want.slot_index) begin
          $error("slot_index: expected %0d, got %0d", want.slot_index, out_item.slot_index);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    in_item_t    it;
    logic [15:0] timeout_plan [PHASES];
    int unsigned burst_left;
    int unsigned per_phase;
    int unsigned pick;

    start       = 1'b0;
    in_item     = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    rst_n       = 1'b0;
    fail_count  = 0;
    cycle_count = 0;
    for (int i = 0; i < ENTRIES; i++) cache_valid[i] = 1'b0;
    clock_secs   = '0;
    timeout_secs = TIMEOUT_RESET;
    ip_pool      = '{32'h0000_0000, 32'hFFFF_FFFF};

    // Directed part: empty table, unused opcode, extremes, duplicates, fill and overflow.
    add_row(make_item(OP_LOOKUP, 32'h0, 48'h0), 1'b1, reply(1'b0, 48'h0, 1'b0, 4'd0));
    add_row(make_item(OP_UNUSED, '1, '1), 1'b1, reply(1'b0, 48'h0, 1'b0, 4'd0));
    add_row(make_item(OP_TICK, 32'h0, 48'h0), 1'b1, reply(1'b0, 48'h0, 1'b0, 4'd0));
    add_row(make_item(OP_INSERT, 32'h0, 48'h0), 1'b1, reply(1'b0, 48'h0, 1'b1, 4'd0));
    add_row(make_item(OP_INSERT, '1, '1), 1'b1, reply(1'b0, 48'h0, 1'b1, 4'd1));
    add_row(make_item(OP_LOOKUP, 32'h0, '1), 1'b1, reply(1'b1, 48'h0, 1'b0, 4'd0));
    add_row(make_item(OP_LOOKUP, '1, 48'h0), 1'b1, reply(1'b1, '1, 1'b0, 4'd1));
    add_row(make_item(OP_INSERT, 32'h0, 48'h1234_5678_9ABC), 1'b1,
            reply(1'b0, 48'h0, 1'b1, 4'd2));
    // A duplicate IP resolves to the highest matching slot.
    add_row(make_item(OP_LOOKUP, 32'h0, 48'h0), 1'b1,
            reply(1'b1, 48'h1234_5678_9ABC, 1'b0, 4'd2));
    add_row(make_item(OP_LOOKUP, 32'h0A00_0001, 48'h0), 1'b1,
            reply(1'b0, 48'h0, 1'b0, 4'd0));
    for (int i = 3; i < ENTRIES; i++)
      add_row(make_item(OP_INSERT, 32'hC0A8_0100 + i, rand_mac()), 1'b0, '0);
    // The table is now full, so this insert is dropped.
    add_row(make_item(OP_INSERT, 32'h0A0A_0A0A, 48'h0), 1'b1,
            reply(1'b0, 48'h0, 1'b0, 4'd0));
    add_row(make_item(OP_LOOKUP, 32'hC0A8_0100 + ENTRIES - 1, 48'h0), 1'b0, '0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) send_item(directed_rows[k].item, directed_rows[k].typed,
                                         directed_rows[k].want);

    // Random part: one phase per timeout setting, the first at the reset value.
    timeout_plan = '{TIMEOUT_RESET, 16'd0, 16'd1, 16'hFFFF, 16'd4, 16'd0, 16'd2, 16'd9};
    timeout_plan[5] = 16'($urandom_range(2, 40));
    per_phase  = RANDOM_ITEMS / PHASES;
    burst_left = 0;
    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) set_timeout(timeout_plan[p]);
      for (int n = 0; n < per_phase; n++) begin
        // Bursts with random gaps; phase 6 runs without gaps.
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if (p != 6 && $urandom_range(0, 3) != 0) hold_off($urandom_range(1, 20));
        end
        burst_left--;
        // Now and then let the block drain completely before going on.
        if ($urandom_range(0, 79) == 0) begin
          hold_off(1);
          wait_drained();
        end
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          it = make_item(OP_LOOKUP, ip_pool[$urandom_range(0, ip_pool.size() - 1)],
                         rand_mac());
        end else if (pick < 38) begin
          it = make_item(OP_LOOKUP, $urandom, rand_mac());
        end else if (pick < 68) begin
          it = make_item(OP_INSERT, $urandom, rand_mac());
          if ($urandom_range(0, 2) == 0)
            it.ip_address = ip_pool[$urandom_range(0, ip_pool.size() - 1)];
          if (ip_pool.size() >= POOL_DEPTH) void'(ip_pool.pop_front());
          ip_pool.push_back(it.ip_address);
        end else if (pick < 95) begin
          it = make_item(OP_TICK, $urandom, rand_mac());
        end else begin
          it = make_item(OP_UNUSED, $urandom, rand_mac());
        end
        send_item(it, 1'b0, '0);
      end
    end

    hold_off(1);
    wait_drained();
    repeat (2 * ENTRIES + 8) @(posedge clk);
    if (pending_replies.size() != 0) begin
      $error("%0d replies never arrived", pending_replies.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
